// File: rtl/imhtq_pkg.sv
// ----------------------------------------------------------------------------
// imhtq_pkg
// Shared types, constants and helpers of the indexed min-heap timer queue.
// ----------------------------------------------------------------------------
package imhtq_pkg;

    localparam int HEAP_DEPTH = 32;
    localparam int ID_SPACE   = 256;
    localparam int HEAP_IDX_W = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int CI_W       = HEAP_IDX_W + 2;
    localparam int ACT_W      = 3;
    localparam int ID_W       = 8;
    localparam int EXP_W      = 32;
    localparam int TO_W       = 20;
    localparam int KIND_W     = 2;
    localparam int WAIT_W     = 21;
    localparam logic [EXP_W-1:0] WAIT_MAX = EXP_W'(1048575);

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK   = 3'd0,
        ACT_ADD    = 3'd1,
        ACT_UPDATE = 3'd2,
        ACT_FIRE   = 3'd3,
        ACT_EXPIRE = 3'd4,
        ACT_CLEAR  = 3'd5
    } t_action;

    typedef enum logic [KIND_W-1:0] {
        KIND_DONE  = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_UNK   = 2'd2,
        KIND_FULL  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [EXP_W-1:0] exp;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_EXP_RD, S_EXP_CHK, S_RM_RD, S_RM_LD,
        S_DN_CHK, S_DN_C1, S_DN_C2, S_DN_CMP, S_DN_END,
        S_UP_CHK, S_UP_CMP, S_PUT, S_FIN, S_FIN_OUT
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP, DP_LATCH, DP_TICK, DP_CLEAR, DP_REARM, DP_INSERT,
        DP_ERR_FULL, DP_ERR_UNK, DP_RM_FIRE, DP_RD_HEAD, DP_EMIT_FIRED,
        DP_RM_RD, DP_RM_LD, DP_RD_C, DP_LATCH_C, DP_PICK_R, DP_DN_MOVE,
        DP_RD_P, DP_UP_MOVE, DP_PUT, DP_EMIT_FINAL
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic known;
        logic full;
        logic out_free;
        logic due;
        logic c_ok;
        logic pick_r;
        logic dn_stop;
        logic moved;
        logic at_root;
        logic up_stop;
        logic rm_move;
    } t_dp_sts;

    // wrap-around time order
    function automatic logic earlier(input logic [EXP_W-1:0] a,
                                     input logic [EXP_W-1:0] b);
        logic [EXP_W-1:0] d;
        d = a - b;
        return d[EXP_W-1];
    endfunction

endpackage

// File: rtl/imhtq_ctrl.sv
// ----------------------------------------------------------------------------
// imhtq_ctrl
// Sequencer of the timer queue: decodes actions and steps the heap sifts.
// ----------------------------------------------------------------------------
module imhtq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  imhtq_pkg::t_dp_sts i_sts,
    output imhtq_pkg::t_dp_cmd o_cmd
);
    import imhtq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_DEC;
            end
            S_DEC: begin
                case (i_sts.act)
                    ACT_ADD: begin
                        if (i_sts.known)     n_state = S_DN_CHK;
                        else if (i_sts.full) n_state = S_FIN;
                        else                 n_state = S_UP_CHK;
                    end
                    ACT_UPDATE: n_state = i_sts.known ? S_DN_CHK : S_FIN;
                    ACT_FIRE:   n_state = i_sts.known ? S_RM_RD : S_FIN;
                    ACT_EXPIRE: n_state = S_EXP_RD;
                    default:    n_state = S_FIN;
                endcase
            end
            S_EXP_RD:  n_state = S_EXP_CHK;
            S_EXP_CHK: begin
                if (!i_sts.due)         n_state = S_FIN;
                else if (i_sts.out_free) n_state = S_RM_RD;
            end
            S_RM_RD:   n_state = S_RM_LD;
            S_RM_LD: begin
                if (i_sts.rm_move)                n_state = S_DN_CHK;
                else if (i_sts.act == ACT_EXPIRE) n_state = S_EXP_RD;
                else                              n_state = S_FIN;
            end
            S_DN_CHK:  n_state = i_sts.c_ok ? S_DN_C1 : S_DN_END;
            S_DN_C1:   n_state = S_DN_C2;
            S_DN_C2:   n_state = S_DN_CMP;
            S_DN_CMP:  n_state = i_sts.dn_stop ? S_DN_END : S_DN_CHK;
            S_DN_END:  n_state = i_sts.moved ? S_PUT : S_UP_CHK;
            S_UP_CHK:  n_state = i_sts.at_root ? S_PUT : S_UP_CMP;
            S_UP_CMP:  n_state = i_sts.up_stop ? S_PUT : S_UP_CHK;
            S_PUT:     n_state = (i_sts.act == ACT_EXPIRE) ? S_EXP_RD : S_FIN;
            S_FIN:     n_state = S_FIN_OUT;
            S_FIN_OUT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready  = 1'b0;
        o_cmd.op = DP_NOP;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) o_cmd.op = DP_LATCH;
            end
            S_DEC: begin
                case (i_sts.act)
                    ACT_TICK:  o_cmd.op = DP_TICK;
                    ACT_CLEAR: o_cmd.op = DP_CLEAR;
                    ACT_ADD: begin
                        if (i_sts.known)     o_cmd.op = DP_REARM;
                        else if (i_sts.full) o_cmd.op = DP_ERR_FULL;
                        else                 o_cmd.op = DP_INSERT;
                    end
                    ACT_UPDATE: o_cmd.op = i_sts.known ? DP_REARM : DP_ERR_UNK;
                    ACT_FIRE:   o_cmd.op = i_sts.known ? DP_RM_FIRE : DP_ERR_UNK;
                    default:    o_cmd.op = DP_NOP;
                endcase
            end
            S_EXP_RD:  o_cmd.op = DP_RD_HEAD;
            S_EXP_CHK: begin
                if (i_sts.due && i_sts.out_free) o_cmd.op = DP_EMIT_FIRED;
            end
            S_RM_RD:   o_cmd.op = DP_RM_RD;
            S_RM_LD: begin
                if (i_sts.rm_move) o_cmd.op = DP_RM_LD;
            end
            S_DN_CHK: begin
                if (i_sts.c_ok) o_cmd.op = DP_RD_C;
            end
            S_DN_C1:   o_cmd.op = DP_LATCH_C;
            S_DN_C2: begin
                if (i_sts.pick_r) o_cmd.op = DP_PICK_R;
            end
            S_DN_CMP: begin
                if (!i_sts.dn_stop) o_cmd.op = DP_DN_MOVE;
            end
            S_UP_CHK: begin
                if (!i_sts.at_root) o_cmd.op = DP_RD_P;
            end
            S_UP_CMP: begin
                if (!i_sts.up_stop) o_cmd.op = DP_UP_MOVE;
            end
            S_PUT:     o_cmd.op = DP_PUT;
            S_FIN:     o_cmd.op = DP_RD_HEAD;
            S_FIN_OUT: begin
                if (i_sts.out_free) o_cmd.op = DP_EMIT_FINAL;
            end
            default:   o_cmd.op = DP_NOP;
        endcase
    end

endmodule

// File: rtl/imhtq_dp.sv
// ----------------------------------------------------------------------------
// imhtq_dp
// Heap and slot memories, tick counter, sift registers and result register.
// ----------------------------------------------------------------------------
module imhtq_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  imhtq_pkg::t_dp_cmd                   i_cmd,
    output imhtq_pkg::t_dp_sts                   o_sts,
    input  logic [imhtq_pkg::ACT_W-1:0]          i_action,
    input  logic [imhtq_pkg::ID_W-1:0]           i_timer_id,
    input  logic [imhtq_pkg::TO_W-1:0]           i_timeout_ms,
    input  logic                                 i_out_ready,
    output logic                                 o_valid,
    output logic [imhtq_pkg::KIND_W-1:0]         o_kind,
    output logic [imhtq_pkg::ID_W-1:0]           o_fired_id,
    output logic signed [imhtq_pkg::WAIT_W-1:0]  o_next_wait,
    output logic                                 o_last
);
    import imhtq_pkg::*;

    t_entry                heap_mem [HEAP_DEPTH];
    logic [HEAP_IDX_W-1:0] slot_mem [ID_SPACE];

    t_entry                r_hrd;
    logic [HEAP_IDX_W-1:0] r_srd;
    logic [EXP_W-1:0]      r_now;
    logic [CNT_W-1:0]      r_count;
    logic [ID_SPACE-1:0]   r_valid;
    logic [ACT_W-1:0]      r_act;
    logic [ID_W-1:0]       r_id;
    logic [TO_W-1:0]       r_to;
    t_entry                r_e;
    t_entry                r_ch;
    logic [HEAP_IDX_W-1:0] r_pos;
    logic [HEAP_IDX_W-1:0] r_start;
    logic [HEAP_IDX_W-1:0] r_cidx;
    logic [CNT_W-1:0]      r_bound;
    logic [ID_W-1:0]       r_rem;
    logic [KIND_W-1:0]     r_kind;
    logic [ID_W-1:0]       r_fid;
    logic                  r_ovalid;
    logic [KIND_W-1:0]     r_okind;
    logic [ID_W-1:0]       r_ofid;
    logic [WAIT_W-1:0]     r_owait;
    logic                  r_olast;

    logic                  h_re;
    logic [HEAP_IDX_W-1:0] h_raddr;
    logic                  h_we;
    logic [HEAP_IDX_W-1:0] h_waddr;
    t_entry                h_wdata;
    logic                  s_we;
    logic [ID_W-1:0]       s_waddr;

    logic [CI_W-1:0]       w_cl;
    logic [CI_W-1:0]       w_cr;
    logic [CI_W-1:0]       w_bound;
    logic [HEAP_IDX_W-1:0] w_parent;
    logic [CNT_W-1:0]      w_cnt_m1;
    logic [EXP_W-1:0]      w_new_exp;
    logic [EXP_W-1:0]      w_diff;
    logic [WAIT_W-1:0]     w_wait;
    logic                  w_out_free;

    assign w_cl      = {1'b0, r_pos, 1'b1};
    assign w_cr      = CI_W'(r_cidx) + CI_W'(1);
    assign w_bound   = CI_W'(r_bound);
    assign w_parent  = HEAP_IDX_W'((r_pos - HEAP_IDX_W'(1)) >> 1);
    assign w_cnt_m1  = r_count - CNT_W'(1);
    assign w_new_exp = r_now + EXP_W'(r_to);
    assign w_diff    = r_hrd.exp - r_now;
    assign w_out_free = !r_ovalid || i_out_ready;

    // wait until head expiry, all ones when empty
    always_comb begin
        if (r_count == '0)           w_wait = '1;
        else if (w_diff[EXP_W-1])    w_wait = '0;
        else if (w_diff > WAIT_MAX)  w_wait = WAIT_W'(WAIT_MAX);
        else                         w_wait = w_diff[WAIT_W-1:0];
    end

    always_comb begin
        o_sts.act      = r_act;
        o_sts.known    = r_valid[r_id];
        o_sts.full     = (r_count == CNT_W'(HEAP_DEPTH));
        o_sts.out_free = w_out_free;
        o_sts.due      = (r_count != '0) &&
                         ((r_hrd.exp == r_now) || earlier(r_hrd.exp, r_now));
        o_sts.c_ok     = (w_cl < w_bound);
        o_sts.pick_r   = (w_cr < w_bound) && earlier(r_hrd.exp, r_ch.exp);
        o_sts.dn_stop  = earlier(r_e.exp, r_ch.exp);
        o_sts.moved    = (r_pos != r_start);
        o_sts.at_root  = (r_pos == '0);
        o_sts.up_stop  = earlier(r_hrd.exp, r_e.exp);
        o_sts.rm_move  = (CNT_W'(r_pos) < r_count);
    end

    // memory port control
    always_comb begin
        h_re    = 1'b0;
        h_raddr = '0;
        h_we    = 1'b0;
        h_waddr = r_pos;
        h_wdata = r_e;
        s_we    = 1'b0;
        s_waddr = r_e.id;
        case (i_cmd.op)
            DP_RD_HEAD: begin
                h_re = 1'b1;
            end
            DP_RM_RD: begin
                h_re    = 1'b1;
                h_raddr = w_cnt_m1[HEAP_IDX_W-1:0];
            end
            DP_RD_C: begin
                h_re    = 1'b1;
                h_raddr = w_cl[HEAP_IDX_W-1:0];
            end
            DP_LATCH_C: begin
                h_re    = 1'b1;
                h_raddr = w_cr[HEAP_IDX_W-1:0];
            end
            DP_RD_P: begin
                h_re    = 1'b1;
                h_raddr = w_parent;
            end
            DP_DN_MOVE: begin
                h_we    = 1'b1;
                h_wdata = r_ch;
                s_we    = 1'b1;
                s_waddr = r_ch.id;
            end
            DP_UP_MOVE: begin
                h_we    = 1'b1;
                h_wdata = r_hrd;
                s_we    = 1'b1;
                s_waddr = r_hrd.id;
            end
            DP_PUT: begin
                h_we = 1'b1;
                s_we = 1'b1;
            end
            default: begin
                h_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (h_we) heap_mem[h_waddr] <= h_wdata;
        if (h_re) r_hrd <= heap_mem[h_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) slot_mem[s_waddr] <= r_pos;
        if (i_cmd.op == DP_LATCH) r_srd <= slot_mem[i_timer_id];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now    <= '0;
            r_count  <= '0;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            case (i_cmd.op)
                DP_TICK:   r_now <= r_now + EXP_W'(1);
                DP_CLEAR: begin
                    r_valid <= '0;
                    r_count <= '0;
                end
                DP_INSERT: begin
                    r_valid[r_id] <= 1'b1;
                    r_count       <= r_count + CNT_W'(1);
                end
                DP_RM_RD: begin
                    r_valid[r_rem] <= 1'b0;
                    r_count        <= w_cnt_m1;
                end
                default: r_count <= r_count;
            endcase
            if (i_cmd.op == DP_EMIT_FIRED || i_cmd.op == DP_EMIT_FINAL) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LATCH: begin
                r_act  <= i_action;
                r_id   <= i_timer_id;
                r_to   <= i_timeout_ms;
                r_kind <= KIND_DONE;
                r_fid  <= '0;
            end
            DP_REARM: begin
                r_e.id  <= r_id;
                r_e.exp <= w_new_exp;
                r_pos   <= r_srd;
                r_start <= r_srd;
                r_bound <= r_count;
            end
            DP_INSERT: begin
                r_e.id  <= r_id;
                r_e.exp <= w_new_exp;
                r_pos   <= r_count[HEAP_IDX_W-1:0];
                r_start <= r_count[HEAP_IDX_W-1:0];
            end
            DP_ERR_FULL: r_kind <= KIND_FULL;
            DP_ERR_UNK:  r_kind <= KIND_UNK;
            DP_RM_FIRE: begin
                r_pos  <= r_srd;
                r_rem  <= r_id;
                r_kind <= KIND_FIRED;
                r_fid  <= r_id;
            end
            DP_EMIT_FIRED: begin
                r_okind <= KIND_FIRED;
                r_ofid  <= r_hrd.id;
                r_owait <= '0;
                r_olast <= 1'b0;
                r_pos   <= '0;
                r_rem   <= r_hrd.id;
            end
            DP_RM_RD: begin
                r_bound <= w_cnt_m1;
                r_start <= r_pos;
            end
            DP_RM_LD:   r_e <= r_hrd;
            DP_RD_C:    r_cidx <= w_cl[HEAP_IDX_W-1:0];
            DP_LATCH_C: r_ch <= r_hrd;
            DP_PICK_R: begin
                r_ch   <= r_hrd;
                r_cidx <= w_cr[HEAP_IDX_W-1:0];
            end
            DP_DN_MOVE: r_pos <= r_cidx;
            DP_UP_MOVE: r_pos <= w_parent;
            DP_EMIT_FINAL: begin
                r_okind <= r_kind;
                r_ofid  <= r_fid;
                r_owait <= w_wait;
                r_olast <= 1'b1;
            end
            default: r_act <= r_act;
        endcase
    end

    assign o_valid     = r_ovalid;
    assign o_kind      = r_okind;
    assign o_fired_id  = r_ofid;
    assign o_next_wait = r_owait;
    assign o_last      = r_olast;

endmodule

// File: rtl/indexed_min_heap_timer_queue_core.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_timer_queue_core
// Timer queue over a 32-entry binary min-heap with an id-to-slot map.
// A sift going down reads both children at each level and moves the earlier
// child up; a sift going up compares the entry with its parent. Add, update
// and fire sift the heap; expire repeats a removal per due timer. One item
// is in work at a time; the result register lets a new item be taken while
// the last result waits. Reset is synchronous, active low, empties the
// queue and zeroes the tick counter.
// ----------------------------------------------------------------------------
module indexed_min_heap_timer_queue_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [imhtq_pkg::ACT_W-1:0]          i_action,
    input  logic [imhtq_pkg::ID_W-1:0]           i_timer_id,
    input  logic [imhtq_pkg::TO_W-1:0]           i_timeout_ms,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [imhtq_pkg::KIND_W-1:0]         o_kind,
    output logic [imhtq_pkg::ID_W-1:0]           o_fired_id,
    output logic signed [imhtq_pkg::WAIT_W-1:0]  o_next_wait,
    output logic                                 o_last
);
    import imhtq_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    imhtq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    imhtq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_action     (i_action),
        .i_timer_id   (i_timer_id),
        .i_timeout_ms (i_timeout_ms),
        .i_out_ready  (i_ready),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_fired_id   (o_fired_id),
        .o_next_wait  (o_next_wait),
        .o_last       (o_last)
    );

endmodule

// File: rtl/imhtq_chk.sv
// ----------------------------------------------------------------------------
// imhtq_chk
// Port-level checks of the timer queue result stream.
// ----------------------------------------------------------------------------
module imhtq_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_ready,
    input logic [imhtq_pkg::ACT_W-1:0]          i_action,
    input logic [imhtq_pkg::ID_W-1:0]           i_timer_id,
    input logic [imhtq_pkg::TO_W-1:0]           i_timeout_ms,
    input logic                                 o_valid,
    input logic                                 i_ready,
    input logic [imhtq_pkg::KIND_W-1:0]         o_kind,
    input logic [imhtq_pkg::ID_W-1:0]           o_fired_id,
    input logic signed [imhtq_pkg::WAIT_W-1:0]  o_next_wait,
    input logic                                 o_last
);
    import imhtq_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) &&
            $stable(o_fired_id) && $stable(o_last))
        else $error("result changed while stalled");

    // only expired timers come before the final item
    a_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_kind == KIND_FIRED && o_next_wait == '0)
        else $error("non-final item is not a fired timer");

    a_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_FIRED |-> o_fired_id == '0)
        else $error("id given without a fired timer");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind indexed_min_heap_timer_queue_core imhtq_chk u_chk (.*);
